// ----- rtl/sorted_priority_queue_macros.svh -----
// Assertion macros used by the module that checks its own logic.
// Each macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/spq_pkg.sv -----
package spq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;

   localparam int VALUE_W = 32;
   localparam int PRIO_W  = 16;
   localparam int OP_W    = 2;
   localparam int STAT_W  = 2;
   localparam int OCC_W   = 5;

   // Only the low bits of the 32-bit input word that fit in DATA_WIDTH are kept.
   localparam int KEEP_W = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [OP_W-1:0] OP_POP   = 2'd1;
   localparam logic [OP_W-1:0] OP_PURGE = 2'd2;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [KEEP_W-1:0]        value;
      logic signed [PRIO_W-1:0] prio;
   } spq_entry_type;

   typedef struct packed {
      logic                     push;
      logic                     shift;
      logic [KEEP_W-1:0]        value;
      logic signed [PRIO_W-1:0] prio;
   } spq_ctrl_type;

endpackage

// ----- rtl/spq_cell.sv -----
module spq_cell (
   input  logic                  clock,
   input  spq_pkg::spq_ctrl_type ctrl,
   input  logic                  live,
   input  logic                  move_left,
   input  spq_pkg::spq_entry_type left_entry,
   input  spq_pkg::spq_entry_type right_entry,
   output spq_pkg::spq_entry_type entry,
   output logic                  move
);
   import spq_pkg::*;

   spq_entry_type entry_ff;
   spq_entry_type entry_in;

   // A cell yields its slot on a push when it is empty or holds a larger priority.
   assign move  = !live || ($signed(entry_ff.prio) > $signed(ctrl.prio));
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.push && move) begin
         if (move_left) begin
            entry_in = left_entry;
         end else begin
            entry_in.value = ctrl.value;
            entry_in.prio  = ctrl.prio;
         end
      end else if (ctrl.shift) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// Sorted priority queue, smallest priority first, first in first out among equals.
// Commands enter on start/busy: an item is taken at a rising edge where start is
// high and busy is low, with req_opcode (push, pop, purge), req_value_in and
// req_prio_in (priority on push, bound on purge).
// Every item gives one result, shown for exactly one cycle with rsp_valid high:
// rsp_value_out (popped word, else zero), rsp_status and rsp_occupancy.
// Push and pop leave busy low: the result appears in the cycle after the item is
// taken, so a new item can be taken in every cycle.
// A purge removes one head entry per cycle through the cell chain and holds busy
// high while the head is at or below the bound; the result shows in the first
// cycle with busy low again. The head compare of the chain decides when it ends.
// Reset empties the queue and clears any pending result; the slot contents are
// left as they are and never read before being written. The receiver cannot hold
// results off, and none is ever withheld or repeated.
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [spq_pkg::OP_W-1:0]     req_opcode,
   input  logic [spq_pkg::VALUE_W-1:0]  req_value_in,
   input  logic signed [spq_pkg::PRIO_W-1:0] req_prio_in,
   output logic                         rsp_valid,
   output logic [spq_pkg::VALUE_W-1:0]  rsp_value_out,
   output logic [spq_pkg::STAT_W-1:0]   rsp_status,
   output logic [spq_pkg::OCC_W-1:0]    rsp_occupancy
);
   import spq_pkg::*;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_PURGE = 1'b1;

   logic                     state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [PRIO_W-1:0] bound_ff, bound_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]       rsp_value_ff, rsp_value_in;
   logic [STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [OCC_W-1:0]         rsp_occ_ff;

   spq_ctrl_type             ctrl;
   spq_entry_type            entries [DEPTH];
   logic                     moves   [DEPTH];
   logic [DEPTH-1:0]         live;

   logic accept;
   logic full;
   logic empty;
   logic head_hit;

   assign busy   = (state_ff == ST_PURGE);
   assign accept = start && !busy;
   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);

   // A purge keeps dropping the head while it is at or below the stored bound.
   assign head_hit = !empty && ($signed(entries[0].prio) <= $signed(bound_ff));

   // Slots below the count hold entries; the rest are free.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         live[i] = (CNT_W'(i) < count_ff);
      end
   end

   // The chain of cells: each cell sees its left and right neighbors and moves
   // in the same cycle as all the others, so a push or a pop updates every slot together.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      spq_entry_type left_entry;
      spq_entry_type right_entry;
      logic          move_left;

      if (g == 0) begin : g_head
         assign left_entry = '0;
         assign move_left  = 1'b0;
      end else begin : g_body
         assign left_entry = entries[g-1];
         assign move_left  = moves[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = entries[g+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .live        (live[g]),
         .move_left   (move_left),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entries[g]),
         .move        (moves[g])
      );
   end

   // Command decode and purge sequencing.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      bound_in      = bound_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = '0;
      rsp_status_in = STATUS_OK;
      ctrl.push     = 1'b0;
      ctrl.shift    = 1'b0;
      ctrl.value    = req_value_in[KEEP_W-1:0];
      ctrl.prio     = req_prio_in;

      if (busy) begin
         if (head_hit) begin
            ctrl.shift = 1'b1;
            count_in   = count_ff - CNT_W'(1);
         end else begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
      end else if (accept) begin
         case (req_opcode)
            OP_PUSH: begin
               rsp_valid_in = 1'b1;
               if (full) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  ctrl.push = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
               end
            end
            OP_POP: begin
               rsp_valid_in = 1'b1;
               if (empty) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  ctrl.shift   = 1'b1;
                  count_in     = count_ff - CNT_W'(1);
                  rsp_value_in = VALUE_W'(entries[0].value);
               end
            end
            OP_PURGE: begin
               bound_in = req_prio_in;
               state_in = ST_PURGE;
            end
            default: begin
               // The unused opcode leaves the queue alone and reports success.
               rsp_valid_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bound_ff      <= bound_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= OCC_W'(count_in);
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;

   // A result never shows while a purge is still walking the chain.
   `SPQ_ASSERT_NOW(a_rsp_idle, rsp_valid, !busy, "result shown while busy")
   // Every command other than purge answers in the very next cycle.
   `SPQ_ASSERT_NEXT(a_rsp_next, accept && (req_opcode != OP_PURGE), rsp_valid,
                    "single-cycle command gave no result")
   // The entry count never exceeds the number of cells.
   `SPQ_ASSERT_NOW(a_count_max, 1'b1, count_ff <= CNT_W'(DEPTH), "entry count overflow")
   // A purge that finds no more entries to drop finishes and answers.
   `SPQ_ASSERT_NEXT(a_purge_end, busy && !head_hit, rsp_valid && !busy,
                    "purge did not finish")

endmodule
